>>> rtl/core/bmoc_pkg.sv
package bmoc_pkg;

  // Item kinds as they arrive on the input channel
  typedef enum logic {
    OpWrite = 1'b0,
    OpQuery = 1'b1
  } op_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CfgWidthA  = 2'd0,
    CfgHeightA = 2'd1,
    CfgWidthB  = 2'd2,
    CfgHeightB = 2'd3
  } cfg_reg_e;

  localparam int unsigned SizeW    = 7;   // size registers
  localparam int unsigned PosW     = 12;  // screen coordinates
  localparam int unsigned CoordW   = 13;  // coordinate plus size
  localparam int unsigned RowW     = 6;   // row field of a write item
  localparam int unsigned MaskW    = 64;  // row word
  localparam int unsigned ShiftW   = 6;   // column alignment
  localparam int unsigned CountW   = 7;   // overlapping rows of a query
  localparam int unsigned MaxAddrW = 10;  // row address at the deepest mask

  // Command passed from the front end to the scan engine
  typedef struct packed {
    op_e                 op;
    logic                which_b;
    logic [MaxAddrW-1:0] addr_a;   // write row, or first row of A
    logic [MaxAddrW-1:0] addr_b;   // first row of B
    logic [ShiftW-1:0]   shift_a;
    logic [ShiftW-1:0]   shift_b;
    logic [CountW-1:0]   rows;     // overlapping rows, zero when apart
    logic [MaskW-1:0]    data;     // row word, or overlap column mask
  } cmd_t;

endpackage

>>> rtl/core/bmoc_ram.sv
module bmoc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word, read one word with a registered output
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/bmoc_front.sv
module bmoc_front #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [1:0]                           cfg_idx_i,
  input  logic [bmoc_pkg::SizeW-1:0]           cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 kind_i,
  input  logic                                 which_mask_i,
  input  logic [bmoc_pkg::RowW-1:0]            row_i,
  input  logic [bmoc_pkg::MaskW-1:0]           row_bits_i,
  input  logic signed [bmoc_pkg::PosW-1:0]     pos_ax_i,
  input  logic signed [bmoc_pkg::PosW-1:0]     pos_ay_i,
  input  logic signed [bmoc_pkg::PosW-1:0]     pos_bx_i,
  input  logic signed [bmoc_pkg::PosW-1:0]     pos_by_i,
  input  logic                                 q_full_i,
  output logic                                 q_push_o,
  output bmoc_pkg::cmd_t                       q_cmd_o
);

  localparam int unsigned CW = bmoc_pkg::CoordW;

  logic [bmoc_pkg::SizeW-1:0] width_a_q, height_a_q, width_b_q, height_b_q;
  logic [bmoc_pkg::SizeW-1:0] wa, ha, wb, hb;
  logic signed [CW-1:0] ax, ay, bx, by, ea, eb, fa, fb;
  logic signed [CW-1:0] x_d, y_d, tx_d, ty_d;

  logic                           s1_valid_q;
  bmoc_pkg::op_e                  s1_op_q;
  logic                           s1_which_q;
  logic [bmoc_pkg::RowW-1:0]      s1_row_q;
  logic [bmoc_pkg::MaskW-1:0]     s1_bits_q;
  logic signed [CW-1:0]           s1_ax_q, s1_ay_q, s1_bx_q, s1_by_q;
  logic signed [CW-1:0]           s1_x_q, s1_y_q, s1_tx_q, s1_ty_q;

  logic signed [CW:0] dx, dy;
  logic [CW-1:0]      sa, sb, ra0, rb0;
  logic               overlap, keep, advance;

  // Hold the size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_a_q  <= 7'd64;
      height_a_q <= 7'd64;
      width_b_q  <= 7'd64;
      height_b_q <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (bmoc_pkg::cfg_reg_e'(cfg_idx_i))
        bmoc_pkg::CfgWidthA:  width_a_q  <= cfg_data_i;
        bmoc_pkg::CfgHeightA: height_a_q <= cfg_data_i;
        bmoc_pkg::CfgWidthB:  width_b_q  <= cfg_data_i;
        bmoc_pkg::CfgHeightB: height_b_q <= cfg_data_i;
      endcase
    end
  end

  // Clamp sizes to the mask store
  always_comb begin
    wa = (width_a_q > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : width_a_q;
    wb = (width_b_q > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : width_b_q;
    ha = (int'(height_a_q) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : height_a_q;
    hb = (int'(height_b_q) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : height_b_q;
  end

  // Intersect the two rectangles: near edges and far edges
  always_comb begin
    ax   = $signed({pos_ax_i[bmoc_pkg::PosW-1], pos_ax_i});
    ay   = $signed({pos_ay_i[bmoc_pkg::PosW-1], pos_ay_i});
    bx   = $signed({pos_bx_i[bmoc_pkg::PosW-1], pos_bx_i});
    by   = $signed({pos_by_i[bmoc_pkg::PosW-1], pos_by_i});
    ea   = ax + $signed({6'b0, wa});
    eb   = bx + $signed({6'b0, wb});
    fa   = ay + $signed({6'b0, ha});
    fb   = by + $signed({6'b0, hb});
    x_d  = (ax > bx) ? ax : bx;
    y_d  = (ay > by) ? ay : by;
    tx_d = (ea < eb) ? ea : eb;
    ty_d = (fa < fb) ? fa : fb;
  end

  // Advance the front stage whenever it is empty or the queue has room
  assign advance    = !s1_valid_q || !q_full_i;
  assign in_stall_o = !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_i) begin
      s1_op_q    <= bmoc_pkg::op_e'(kind_i);
      s1_which_q <= which_mask_i;
      s1_row_q   <= row_i;
      s1_bits_q  <= row_bits_i;
      s1_ax_q    <= ax;
      s1_ay_q    <= ay;
      s1_bx_q    <= bx;
      s1_by_q    <= by;
      s1_x_q     <= x_d;
      s1_y_q     <= y_d;
      s1_tx_q    <= tx_d;
      s1_ty_q    <= ty_d;
    end
  end

  // Classify: overlap extent, alignment shifts and first rows
  always_comb begin
    dx      = $signed({s1_tx_q[CW-1], s1_tx_q}) - $signed({s1_x_q[CW-1], s1_x_q});
    dy      = $signed({s1_ty_q[CW-1], s1_ty_q}) - $signed({s1_y_q[CW-1], s1_y_q});
    overlap = (dx > 0) && (dy > 0);
    sa      = s1_x_q - s1_ax_q;
    sb      = s1_x_q - s1_bx_q;
    ra0     = s1_y_q - s1_ay_q;
    rb0     = s1_y_q - s1_by_q;
  end

  // Build the command; drop writes beyond the mask depth
  always_comb begin
    q_cmd_o         = '0;
    q_cmd_o.op      = s1_op_q;
    q_cmd_o.which_b = s1_which_q;
    if (s1_op_q == bmoc_pkg::OpWrite) begin
      keep           = int'(s1_row_q) < MAX_HEIGHT;
      q_cmd_o.addr_a = bmoc_pkg::MaxAddrW'(s1_row_q);
      q_cmd_o.data   = s1_bits_q;
    end else begin
      keep            = 1'b1;
      q_cmd_o.addr_a  = ra0[bmoc_pkg::MaxAddrW-1:0];
      q_cmd_o.addr_b  = rb0[bmoc_pkg::MaxAddrW-1:0];
      q_cmd_o.shift_a = sa[bmoc_pkg::ShiftW-1:0];
      q_cmd_o.shift_b = sb[bmoc_pkg::ShiftW-1:0];
      q_cmd_o.rows    = overlap ? dy[bmoc_pkg::CountW-1:0] : '0;
      q_cmd_o.data    = ~({bmoc_pkg::MaskW{1'b1}} << dx[bmoc_pkg::CountW-1:0]);
    end
  end

  assign q_push_o = s1_valid_q && keep && !q_full_i;

endmodule

>>> rtl/core/bmoc_queue.sv
module bmoc_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bmoc_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  output logic           valid_o,
  output bmoc_pkg::cmd_t head_o,
  input  logic           pop_i
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  bmoc_pkg::cmd_t  entry_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PW:0]     count_q;

  assign full_o  = (count_q == (PW+1)'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = entry_q[rd_ptr_q];

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i)
    else $error("queue pushed while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue popped while empty");

endmodule

>>> rtl/core/bmoc_back.sv
module bmoc_back #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  bmoc_pkg::cmd_t q_head_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           collides_o
);

  localparam int unsigned AW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_e;

  state_e                        state_q, state_d;
  logic [AW-1:0]                 addr_a_q, addr_a_d, addr_b_q, addr_b_d;
  logic [bmoc_pkg::ShiftW-1:0]   shift_a_q, shift_a_d, shift_b_q, shift_b_d;
  logic [MAX_WIDTH-1:0]          mask_q, mask_d;
  logic [bmoc_pkg::CountW-1:0]   left_q, left_d;
  logic                          hit_q, hit_d;
  logic                          out_valid_q, out_valid_d;
  logic                          collides_q, collides_d;

  logic                 we_a, we_b, re;
  logic [AW-1:0]        raddr_a, raddr_b, waddr;
  logic [MAX_WIDTH-1:0] rdata_a, rdata_b, wdata;
  logic                 hit_now, start_write, start_query;

  assign start_write = (state_q == S_IDLE) && q_valid_i && (q_head_i.op == bmoc_pkg::OpWrite);
  assign start_query = (state_q == S_IDLE) && q_valid_i && (q_head_i.op == bmoc_pkg::OpQuery);
  assign q_pop_o     = (state_q == S_IDLE) && q_valid_i;

  // Row writes go straight into the selected mask
  assign waddr = q_head_i.addr_a[AW-1:0];
  assign wdata = q_head_i.data[MAX_WIDTH-1:0];
  assign we_a  = start_write && !q_head_i.which_b;
  assign we_b  = start_write && q_head_i.which_b;

  // Compare the row pair read in the previous cycle
  assign hit_now = |((rdata_a >> shift_a_q) & (rdata_b >> shift_b_q) & mask_q);

  // Issue the first row pair from the command, then from the counters
  always_comb begin
    raddr_a = (state_q == S_IDLE) ? q_head_i.addr_a[AW-1:0] : addr_a_q;
    raddr_b = (state_q == S_IDLE) ? q_head_i.addr_b[AW-1:0] : addr_b_q;
    re      = (start_query && (q_head_i.rows != '0)) ||
              ((state_q == S_SCAN) && !hit_now && (left_q != '0));
  end

  bmoc_ram #(
    .WIDTH (MAX_WIDTH),
    .DEPTH (MAX_HEIGHT)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  bmoc_ram #(
    .WIDTH (MAX_WIDTH),
    .DEPTH (MAX_HEIGHT)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  // Scan sequencer
  always_comb begin
    state_d     = state_q;
    addr_a_d    = addr_a_q;
    addr_b_d    = addr_b_q;
    shift_a_d   = shift_a_q;
    shift_b_d   = shift_b_q;
    mask_d      = mask_q;
    left_d      = left_q;
    hit_d       = hit_q;
    collides_d  = collides_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (start_query) begin
          shift_a_d = q_head_i.shift_a;
          shift_b_d = q_head_i.shift_b;
          mask_d    = q_head_i.data[MAX_WIDTH-1:0];
          addr_a_d  = q_head_i.addr_a[AW-1:0] + 1'b1;
          addr_b_d  = q_head_i.addr_b[AW-1:0] + 1'b1;
          if (q_head_i.rows == '0) begin
            hit_d   = 1'b0;
            state_d = S_RESULT;
          end else begin
            left_d  = q_head_i.rows - 1'b1;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit_now) begin
          hit_d   = 1'b1;
          state_d = S_RESULT;
        end else if (left_q == '0) begin
          hit_d   = 1'b0;
          state_d = S_RESULT;
        end else begin
          addr_a_d = addr_a_q + 1'b1;
          addr_b_d = addr_b_q + 1'b1;
          left_d   = left_q - 1'b1;
        end
      end
      S_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          collides_d  = hit_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state, scan registers and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      left_q      <= '0;
      hit_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      left_q      <= left_d;
      hit_q       <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_a_q   <= addr_a_d;
    addr_b_q   <= addr_b_d;
    shift_a_q  <= shift_a_d;
    shift_b_q  <= shift_b_d;
    mask_q     <= mask_d;
    collides_q <= collides_d;
  end

  assign out_valid_o = out_valid_q;
  assign collides_o  = collides_q;

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we_a || we_b) |-> (state_q == S_IDLE) && !re)
    else $error("mask write outside idle or during a read");

  a_load_from_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_RESULT)
    else $error("result loaded outside the result state");

  a_scan_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) && !hit_now && (left_q == '0) |=> (state_q == S_RESULT))
    else $error("scan ran past its last row");

endmodule

>>> rtl/core/bitmask_overlap_collision_core.sv
// Pixel-exact collision test of two one-bit-per-pixel sprite masks.
// Input channel (in_valid_i / in_stall_o): kind_i = 0 stores row_bits_i as
// row row_i of mask A or B (which_mask_i) and gives no result; kind_i = 1
// is a query with the screen positions of both sprites. Output channel
// (out_valid_o / out_stall_i) returns one collides_o item per query.
// Sizes in use are set through cfg_we_i / cfg_idx_i / cfg_data_i while idle.
// A front stage intersects the two rectangles, a two-entry command queue
// decouples it from the scan engine, which reads one row pair of both
// mask memories per cycle and stops at the first common opaque pixel.
// A query scans row pairs up to the first hit, at most the overlap height,
// limited by the single read port of each mask memory. An accepted item
// passes the front stage register and the queue on its way to the engine.
// Reset clears the sizes to 64, empties the queue and the output register;
// mask contents are not cleared and must be written before they are read.
// When the receiver stalls, the result holds, the engine waits with its
// next result, and the queue keeps accepting items until it is full.
module bitmask_overlap_collision_core #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_idx_i,
  input  logic [bmoc_pkg::SizeW-1:0]       cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             kind_i,
  input  logic                             which_mask_i,
  input  logic [bmoc_pkg::RowW-1:0]        row_i,
  input  logic [bmoc_pkg::MaskW-1:0]       row_bits_i,
  input  logic signed [bmoc_pkg::PosW-1:0] pos_ax_i,
  input  logic signed [bmoc_pkg::PosW-1:0] pos_ay_i,
  input  logic signed [bmoc_pkg::PosW-1:0] pos_bx_i,
  input  logic signed [bmoc_pkg::PosW-1:0] pos_by_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             collides_o
);

  logic           q_full, q_push, q_valid, q_pop;
  bmoc_pkg::cmd_t q_cmd, q_head;

  bmoc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .which_mask_i (which_mask_i),
    .row_i        (row_i),
    .row_bits_i   (row_bits_i),
    .pos_ax_i     (pos_ax_i),
    .pos_ay_i     (pos_ay_i),
    .pos_bx_i     (pos_bx_i),
    .pos_by_i     (pos_by_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (q_cmd)
  );

  bmoc_queue #(
    .DEPTH (2)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_cmd),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .head_o     (q_head),
    .pop_i      (q_pop)
  );

  bmoc_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .collides_o  (collides_o)
  );

endmodule
